[rtl/core/iswd_pkg.sv]
// Package for the integer sorter: payload structs, cell control struct,
// sequencer state type and sizing constants. No dependencies.
package iswd_pkg;

    localparam int DATA_W           = 32;
    localparam int MAX_ELEMENTS_DEF = 64;

    // APB register map (byte addresses, word aligned)
    localparam int PADDR_W          = 3;
    localparam int PDATA_W          = 32;
    localparam logic REG_IDX_SORT_DESC = 1'b0;   // paddr[2] of the direction register

    typedef struct packed {
        logic signed [DATA_W-1:0] element_value;
        logic                     is_final;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] sorted_value;
        logic                     end_of_run;
        logic                     dropped_flag;
    } t_out_item;

    // one operation per cycle for the whole row of cells
    typedef struct packed {
        logic insert;
        logic shift_up;
        logic shift_down;
    } t_cell_ctl;

    typedef enum logic {
        ST_LOAD,
        ST_EMIT
    } t_state;

endpackage

[rtl/core/iswd_cell.sv]
// One cell of the sorting row: holds one element and its valid bit.
// Depends on iswd_pkg.
module iswd_cell (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  iswd_pkg::t_cell_ctl              i_ctl,
    input  logic signed [iswd_pkg::DATA_W-1:0] i_new_value,
    input  logic                             i_left_ins,
    input  logic                             i_left_valid,
    input  logic signed [iswd_pkg::DATA_W-1:0] i_left_value,
    input  logic                             i_right_valid,
    input  logic signed [iswd_pkg::DATA_W-1:0] i_right_value,
    output logic                             o_ins,
    output logic                             o_valid,
    output logic signed [iswd_pkg::DATA_W-1:0] o_value
);
    import iswd_pkg::*;

    logic                     r_valid;
    logic                     n_valid;
    logic signed [DATA_W-1:0] r_value;
    logic signed [DATA_W-1:0] n_value;

    // row is kept ascending; new value belongs at or before this cell
    assign o_ins   = !r_valid || (i_new_value < r_value);
    assign o_valid = r_valid;
    assign o_value = r_value;

    always_comb begin
        n_valid = r_valid;
        n_value = r_value;
        if (i_ctl.insert) begin
            if (i_left_ins) begin
                n_valid = i_left_valid;
                n_value = i_left_value;
            end else if (o_ins) begin
                n_valid = 1'b1;
                n_value = i_new_value;
            end
        end else if (i_ctl.shift_up) begin
            n_valid = i_left_valid;
            n_value = i_left_value;
        end else if (i_ctl.shift_down) begin
            n_valid = i_right_valid;
            n_value = i_right_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_value <= n_value;
    end

endmodule

[rtl/core/iswd_ctrl.sv]
// Sequencer for the sorter: load/emit state, fill count, overflow flag
// and the count of results still to go. Depends on iswd_pkg.
module iswd_ctrl #(
    parameter int MAX_ELEMENTS = iswd_pkg::MAX_ELEMENTS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                i_is_final,
    input  logic                i_desc,
    input  logic                i_top_valid,
    output iswd_pkg::t_cell_ctl o_ctl,
    output logic                o_emit,
    output logic                o_last,
    output logic                o_dropped,
    output logic                o_busy
);
    import iswd_pkg::*;

    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ELEMENTS);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    t_state           r_state;
    t_state           n_state;
    logic [CNT_W-1:0] r_fill;
    logic [CNT_W-1:0] n_fill;
    logic [CNT_W-1:0] r_remain;
    logic [CNT_W-1:0] n_remain;
    logic             r_ovf;
    logic             n_ovf;

    logic accept;
    logic full;

    assign full = (r_fill == CNT_MAX);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD: if (i_start && i_is_final) n_state = ST_EMIT;
            ST_EMIT: if (o_last)                n_state = ST_LOAD;
            default: n_state = ST_LOAD;
        endcase
    end

    // outputs
    always_comb begin
        o_busy = 1'b0;
        accept = 1'b0;
        o_ctl  = '0;
        o_emit = 1'b0;
        unique case (r_state)
            ST_LOAD: begin
                accept       = i_start;
                o_ctl.insert = i_start && !full;
            end
            ST_EMIT: begin
                o_busy = 1'b1;
                // descending drains the top end once the set has moved up to it
                if (i_desc) begin
                    o_ctl.shift_up = 1'b1;
                    o_emit         = i_top_valid;
                end else begin
                    o_ctl.shift_down = 1'b1;
                    o_emit           = 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign o_last    = o_emit && (r_remain == CNT_ONE);
    assign o_dropped = r_ovf;

    always_comb begin
        n_fill   = r_fill;
        n_remain = r_remain;
        n_ovf    = r_ovf;
        if (accept) begin
            if (full) begin
                n_ovf = 1'b1;
            end else begin
                n_fill = r_fill + CNT_ONE;
            end
            if (i_is_final) begin
                n_remain = full ? CNT_MAX : r_fill + CNT_ONE;
            end
        end
        if (o_emit) begin
            n_remain = r_remain - CNT_ONE;
        end
        if (o_last) begin
            n_fill = '0;
            n_ovf  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_LOAD;
            r_fill   <= '0;
            r_remain <= '0;
            r_ovf    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_fill   <= n_fill;
            r_remain <= n_remain;
            r_ovf    <= n_ovf;
        end
    end

endmodule

[rtl/core/integer_sort_with_direction.sv]
// Top level of the integer sorter: APB direction register, sequencer and
// a row of insertion cells. Depends on iswd_pkg, iswd_cell, iswd_ctrl.
//
//  channel   | handshake                          | payload
//  ----------+------------------------------------+----------------------
//  input     | start && !busy                     | i_item (t_in_item)
//  result    | o_valid, one cycle, no back-press. | o_result (t_out_item)
//  config    | psel && penable && pwrite (pready) | pwdata[0] at paddr 0
//
// Loading: one element per cycle, inserted in order across the cell row.
// A final element starts emission; busy stays high while the row drains.
// Ascending: the first result follows the state and result registers, then
// one per cycle. Descending: the set first shifts up to reach the top cell.
// Reset clears cell valid bits, counters and the direction register; the
// result side is never stalled.
module integer_sort_with_direction #(
    parameter int MAX_ELEMENTS = iswd_pkg::MAX_ELEMENTS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  iswd_pkg::t_in_item             i_item,
    output logic                           o_valid,
    output iswd_pkg::t_out_item            o_result,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [iswd_pkg::PADDR_W-1:0]   paddr,
    input  logic [iswd_pkg::PDATA_W-1:0]   pwdata,
    output logic [iswd_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready
);
    import iswd_pkg::*;

    logic      r_desc;
    t_cell_ctl ctl;
    logic      emit;
    logic      last;
    logic      dropped;

    logic                     cell_ins   [MAX_ELEMENTS];
    logic                     cell_valid [MAX_ELEMENTS];
    logic signed [DATA_W-1:0] cell_value [MAX_ELEMENTS];

    logic      r_out_valid;
    t_out_item r_out;

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_IDX_SORT_DESC) ? {{(PDATA_W-1){1'b0}}, r_desc} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_desc <= 1'b0;
        end else if (psel && penable && pwrite && paddr[2] == REG_IDX_SORT_DESC) begin
            r_desc <= pwdata[0];
        end
    end

    iswd_ctrl #(
        .MAX_ELEMENTS(MAX_ELEMENTS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_is_final (i_item.is_final),
        .i_desc     (r_desc),
        .i_top_valid(cell_valid[MAX_ELEMENTS-1]),
        .o_ctl      (ctl),
        .o_emit     (emit),
        .o_last     (last),
        .o_dropped  (dropped),
        .o_busy     (busy)
    );

    for (genvar g = 0; g < MAX_ELEMENTS; g++) begin : g_cell
        logic                     left_ins;
        logic                     left_valid;
        logic signed [DATA_W-1:0] left_value;
        logic                     right_valid;
        logic signed [DATA_W-1:0] right_value;

        if (g == 0) begin : g_first
            assign left_ins   = 1'b0;
            assign left_valid = 1'b0;
            assign left_value = '0;
        end else begin : g_mid
            assign left_ins   = cell_ins[g-1];
            assign left_valid = cell_valid[g-1];
            assign left_value = cell_value[g-1];
        end

        if (g == MAX_ELEMENTS - 1) begin : g_last
            assign right_valid = 1'b0;
            assign right_value = '0;
        end else begin : g_inner
            assign right_valid = cell_valid[g+1];
            assign right_value = cell_value[g+1];
        end

        iswd_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (ctl),
            .i_new_value  (i_item.element_value),
            .i_left_ins   (left_ins),
            .i_left_valid (left_valid),
            .i_left_value (left_value),
            .i_right_valid(right_valid),
            .i_right_value(right_value),
            .o_ins        (cell_ins[g]),
            .o_valid      (cell_valid[g]),
            .o_value      (cell_value[g])
        );
    end

    // result register: ascending pops cell 0, descending pops the top cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= emit;
        end
        r_out.sorted_value <= r_desc ? cell_value[MAX_ELEMENTS-1] : cell_value[0];
        r_out.end_of_run   <= last;
        r_out.dropped_flag <= dropped;
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

[rtl/core/iswd_checker.sv]
// Port-level checks for the integer sorter and the bind that attaches them.
// Depends on iswd_pkg and integer_sort_with_direction.
module iswd_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic                busy,
    input iswd_pkg::t_in_item  i_item,
    input logic                o_valid,
    input iswd_pkg::t_out_item o_result
);
    import iswd_pkg::*;

    // a final element always opens an emission phase
    a_final_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_item.is_final |=> busy)
        else $error("final transaction did not start emission");

    // a non-final element never blocks the next one
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && !i_item.is_final |=> !busy)
        else $error("non-final transaction raised busy");

    // emission ends exactly with the last result of the set
    a_fall_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_valid && o_result.end_of_run)
        else $error("busy dropped without end of run");

    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.end_of_run |=> !o_valid)
        else $error("result after end of run");

endmodule

bind integer_sort_with_direction iswd_checker u_iswd_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .i_item  (i_item),
    .o_valid (o_valid),
    .o_result(o_result)
);
